### rtl/core/sfs_pkg.sv
// shared types, constants and the crc byte update of the sample frame serializer
package sfs_pkg;

  // input request layout on the slave stream data bus
  localparam int SampleW      = 256;
  localparam int SeqLsb       = 0;
  localparam int TstampLsb    = 32;
  localparam int AnalogLsb    = 64;
  localparam int DigitalLsb   = 192;
  localparam int SpeedLsb     = 208;
  localparam int FlagsLsb     = 240;

  // analog channel count limits
  localparam int AnalogChannelsDef = 4;
  localparam int MaxChannels       = 4;

  // configuration port widths
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MAGIC    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_VERSION  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_TYPE     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_PAYLD_LEN = CfgIdxW'(3);

  localparam logic [15:0] PayloadLenReset = 16'd34;

  // crc-16/modbus, reflected
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // configuration register contents
  typedef struct packed {
    logic [7:0]  magic;
    logic [7:0]  version;
    logic [7:0]  stype;
    logic [15:0] plen;
  } cfg_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_e;

  // byte source for the output register
  typedef enum logic [1:0] {
    SEL_BODY   = 2'd0,
    SEL_CRC_LO = 2'd1,
    SEL_CRC_HI = 2'd2
  } sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic emit;
    sel_e sel;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

### rtl/core/sample_frame_serializer_crc16_unit.sv
// top level of the sample frame serializer with crc-16/modbus
//
//  channel    direction  payload
//  s_axis     in         one measurement sample (tdata 256 bits)
//  m_axis     out        one frame byte (tdata 8 bits), tlast on the final byte
//  cfg        in         header register write (index 8 bits, data 16 bits)
//
//  a frame is 23 + 4*AnalogChannels bytes (39 at four, the cap), one byte per cycle
//  while m_axis is ready; the byte counter of the sequencer sets the pace; the next
//  sample is taken in the cycle the last byte enters the output register
//  reset clears the sequencer and output valid and seeds the crc; header registers take defaults
//  a stalled m_axis holds the output register and freezes the sequencer
module sample_frame_serializer_crc16_unit
  import sfs_pkg::*;
#(
  parameter int AnalogChannels = AnalogChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // fields from bit 0: sequence_number, capture_ms, analog_ch0, analog_ch1,
  // analog_ch2, analog_ch3, digital_inputs, shaft_speed, status_flags
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,
  // fields from bit 0: frame_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // header registers
  sfs_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer
  sfs_ctrl #(
    .AnalogChannels (AnalogChannels)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // frame datapath
  sfs_dp #(
    .AnalogChannels (AnalogChannels)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .cfg_i     (cfg),
    .sample_i  (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

### rtl/core/sfs_regs.sv
// configuration registers for the frame header
module sfs_regs
  import sfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register write decode, unknown indexes dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAGIC:     cfg_d.magic   = cfg_data_i[7:0];
        REG_VERSION:   cfg_d.version = cfg_data_i[7:0];
        REG_TYPE:      cfg_d.stype   = cfg_data_i[7:0];
        REG_PAYLD_LEN: cfg_d.plen    = cfg_data_i[15:0];
        default:       cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{magic: 8'h00, version: 8'h00, stype: 8'h00, plen: PayloadLenReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/sfs_ctrl.sv
// frame sequencer: byte counter and send state machine
module sfs_ctrl
  import sfs_pkg::*;
#(
  parameter int AnalogChannels = AnalogChannelsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam int NumCh      = (AnalogChannels > MaxChannels) ? MaxChannels : AnalogChannels;
  localparam int BodyBytes  = 21 + 4 * NumCh;
  localparam int FrameBytes = BodyBytes + 2;
  localparam int PosW       = $clog2(FrameBytes);

  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            emit_ok;
  logic            last_emit;

  // command decode from state and byte position
  always_comb begin
    emit_ok   = (state_q == ST_SEND) && status_i.out_free;
    last_emit = emit_ok && (pos_q == PosW'(FrameBytes - 1));
    in_ready_o = (state_q == ST_IDLE) || last_emit;

    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.emit = emit_ok;
    if (pos_q < PosW'(BodyBytes)) begin
      cmd_o.sel = SEL_BODY;
    end else if (pos_q == PosW'(BodyBytes)) begin
      cmd_o.sel = SEL_CRC_LO;
    end else begin
      cmd_o.sel = SEL_CRC_HI;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_SEND;
          pos_d   = '0;
        end
      end
      ST_SEND: begin
        if (last_emit) begin
          pos_d   = '0;
          state_d = cmd_o.load ? ST_SEND : ST_IDLE;
        end else if (emit_ok) begin
          pos_d = pos_q + PosW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // bytes only leave while a frame is in flight
  a_emit_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> state_q == ST_SEND)
    else $error("byte emitted outside a frame");

  // counter stays inside the frame
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(FrameBytes - 1))
    else $error("byte position past frame end");

  // a new request always restarts at the first header byte
  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_SEND && pos_q == '0)
    else $error("frame did not restart after request");

  // frame end without a waiting request returns to idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_emit && !cmd_o.load |=> state_q == ST_IDLE)
    else $error("controller did not return to idle");

endmodule

### rtl/core/sfs_dp.sv
// datapath: frame body shift register, crc and output register
module sfs_dp
  import sfs_pkg::*;
#(
  parameter int AnalogChannels = AnalogChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  cfg_t               cfg_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [7:0]         m_data_o,
  output logic               m_last_o
);

  localparam int NumCh     = (AnalogChannels > MaxChannels) ? MaxChannels : AnalogChannels;
  localparam int BodyBytes = 21 + 4 * NumCh;
  localparam int BodyBits  = 8 * BodyBytes;
  localparam int TailLsb   = 104 + 32 * NumCh;

  logic [BodyBits-1:0] body_q, body_d;
  logic [15:0]         crc_q;
  logic                out_valid_q;
  logic [7:0]          out_data_q;
  logic                out_last_q;
  logic [7:0]          emit_byte;

  // frame body, first byte in the lowest bits
  always_comb begin
    body_d             = '0;
    body_d[7:0]        = cfg_i.magic;
    body_d[15:8]       = cfg_i.version;
    body_d[23:16]      = cfg_i.stype;
    body_d[39:24]      = cfg_i.plen;
    body_d[71:40]      = sample_i[SeqLsb +: 32];
    body_d[103:72]     = sample_i[TstampLsb +: 32];
    for (int ch = 0; ch < NumCh; ch++) begin
      body_d[104 + 32 * ch +: 32] = sample_i[AnalogLsb + 32 * ch +: 32];
    end
    body_d[TailLsb +: 16]      = sample_i[DigitalLsb +: 16];
    body_d[TailLsb + 16 +: 32] = sample_i[SpeedLsb +: 32];
    body_d[TailLsb + 48 +: 16] = sample_i[FlagsLsb +: 16];
  end

  // byte source select
  always_comb begin
    case (cmd_i.sel)
      SEL_BODY:   emit_byte = body_q[7:0];
      SEL_CRC_LO: emit_byte = crc_q[7:0];
      SEL_CRC_HI: emit_byte = crc_q[15:8];
      default:    emit_byte = body_q[7:0];
    endcase
  end

  assign status_o.out_free = !out_valid_q || m_ready_i;

  // body shift register, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      body_q <= body_d;
    end else if (cmd_i.emit && cmd_i.sel == SEL_BODY) begin
      body_q <= body_q >> 8;
    end
  end

  // running crc over the body bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else if (cmd_i.load) begin
      crc_q <= CrcInit;
    end else if (cmd_i.emit && cmd_i.sel == SEL_BODY) begin
      crc_q <= crc_update(crc_q, body_q[7:0]);
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= emit_byte;
      out_last_q <= (cmd_i.sel == SEL_CRC_HI);
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

  // never overwrite a byte still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || m_ready_i)
    else $error("output byte overwritten");

  // crc restarts from its seed for each request
  a_crc_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> crc_q == CrcInit)
    else $error("crc not reseeded");

  // last flag only on the crc high byte
  a_last_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_last_q == $past(cmd_i.sel == SEL_CRC_HI))
    else $error("last flag on wrong byte");

endmodule
